// ===== sv/formula_tokenizer_with_cell_decode_assert.svh =====
// Assertion macros for the formula tokenizer; clocked on clk, disabled while rst_n is low.
`ifndef FORMULA_TOKENIZER_WITH_CELL_DECODE_ASSERT_SVH
`define FORMULA_TOKENIZER_WITH_CELL_DECODE_ASSERT_SVH

// Same-cycle implication: the consequent must hold wherever the antecedent holds.
`define FTOK_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define FTOK_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ftok_pkg.sv =====
// Shared constants, codes and types of the formula tokenizer.
package ftok_pkg;

    // Limits of the lexer.
    localparam int MAX_LEN  = 4096;
    localparam int MAX_COLS = 16384;
    localparam int MAX_ROWS = 1048576;

    // Internal widths derived from the limits.
    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int PSTART_W  = $clog2(MAX_LEN);
    localparam int COL_ACC_W = $clog2(MAX_COLS + 2);
    localparam int ROW_ACC_W = $clog2(MAX_ROWS + 2);

    // Widths of the token fields.
    localparam int TYPE_W  = 4;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int COL_W   = 14;
    localparam int ROW_W   = 20;
    localparam int ERR_W   = 3;
    localparam int CHAR_W  = 8;

    // Token queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token types.
    localparam logic [TYPE_W-1:0] TK_END    = 4'd0;
    localparam logic [TYPE_W-1:0] TK_NUMBER = 4'd1;
    localparam logic [TYPE_W-1:0] TK_CELL   = 4'd2;
    localparam logic [TYPE_W-1:0] TK_PLUS   = 4'd3;
    localparam logic [TYPE_W-1:0] TK_MINUS  = 4'd4;
    localparam logic [TYPE_W-1:0] TK_MUL    = 4'd5;
    localparam logic [TYPE_W-1:0] TK_DIV    = 4'd6;
    localparam logic [TYPE_W-1:0] TK_LPAREN = 4'd7;
    localparam logic [TYPE_W-1:0] TK_RPAREN = 4'd8;
    localparam logic [TYPE_W-1:0] TK_ERROR  = 4'd9;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NO_ROW   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_ROW_ZERO = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LIMIT    = 3'd4;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    // 'A' maps to letter value one, so letters are biased by the code before 'A'.
    localparam logic [CHAR_W-1:0] CH_LETTER_BIAS = 8'h40;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_NUMBER  = 5'b00010,
        MODE_LETTERS = 5'b00100,
        MODE_DIGITS  = 5'b01000,
        MODE_ERROR   = 5'b10000
    } lex_mode_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  token_type;
        logic [START_W-1:0] token_start;
        logic [LEN_W-1:0]   token_length;
        logic [COL_W-1:0]   cell_col;
        logic [ROW_W-1:0]   cell_row;
        logic [ERR_W-1:0]   error_code;
        logic               last;
    } token_t;

    // Up to two tokens per character, pushed in order a then b.
    typedef struct packed {
        logic   push_a;
        token_t tok_a;
        logic   push_b;
        token_t tok_b;
    } token_push_t;

    typedef struct packed {
        logic              room;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

// ===== sv/ftok_if.sv =====
// Handshake interfaces for the character stream and the token stream.
interface ftok_char_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [ftok_pkg::CHAR_W-1:0] ch;

    modport source (output valid, kind, ch, input ready);
    modport sink (input valid, kind, ch, output ready);
endinterface

interface ftok_token_if;
    logic                         valid;
    logic                         ready;
    logic [ftok_pkg::TYPE_W-1:0]  token_type;
    logic [ftok_pkg::START_W-1:0] token_start;
    logic [ftok_pkg::LEN_W-1:0]   token_length;
    logic [ftok_pkg::COL_W-1:0]   cell_col;
    logic [ftok_pkg::ROW_W-1:0]   cell_row;
    logic [ftok_pkg::ERR_W-1:0]   error_code;
    logic                         last;

    modport source (output valid, token_type, token_start, token_length, cell_col,
                    cell_row, error_code, last, input ready);
    modport sink (input valid, token_type, token_start, token_length, cell_col,
                  cell_row, error_code, last, output ready);
endinterface

// ===== sv/ftok_lexer.sv =====
// Lexer state registers and the combinational step that turns one character into tokens.
module ftok_lexer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           kind,
    input  logic [ftok_pkg::CHAR_W-1:0]    ch,
    output ftok_pkg::token_push_t          push,
    output ftok_pkg::lex_mode_t            mode
);

    localparam int COL_PROD_W = ftok_pkg::COL_ACC_W + 5;
    localparam int ROW_PROD_W = ftok_pkg::ROW_ACC_W + 4;

    ftok_pkg::lex_mode_t                  mode_reg, mode_next;
    logic [ftok_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [ftok_pkg::PSTART_W-1:0]        pstart_reg, pstart_next;
    logic [ftok_pkg::COL_ACC_W-1:0]       col_reg, col_next;
    logic [ftok_pkg::ROW_ACC_W-1:0]       row_reg, row_next;
    logic                                 lim_reg, lim_next;

    logic                                 consumed;
    logic                                 cell_ok;
    logic [ftok_pkg::LEN_W-1:0]           pend_len;
    logic [ftok_pkg::START_W-1:0]         pend_start;
    ftok_pkg::token_t                     cell_tok;
    ftok_pkg::token_t                     tok_a, tok_b;
    logic                                 push_a, push_b;
    logic [ftok_pkg::COL_ACC_W:0]         letter_cont, letter_first;
    logic [ftok_pkg::ROW_ACC_W:0]         digit_cont, digit_first;

    function automatic logic is_digit(input logic [ftok_pkg::CHAR_W-1:0] c);
        return (c >= ftok_pkg::CH_ZERO) && (c <= ftok_pkg::CH_NINE);
    endfunction

    function automatic logic is_upper(input logic [ftok_pkg::CHAR_W-1:0] c);
        return (c >= ftok_pkg::CH_UPPER_A) && (c <= ftok_pkg::CH_UPPER_Z);
    endfunction

    function automatic logic is_space(input logic [ftok_pkg::CHAR_W-1:0] c);
        return (c == ftok_pkg::CH_SPACE) || ((c >= ftok_pkg::CH_TAB) && (c <= ftok_pkg::CH_CR));
    endfunction

    // Returns {limit hit, new column accumulator}; saturates at MAX_COLS + 1.
    function automatic logic [ftok_pkg::COL_ACC_W:0] add_letter(
        input logic [ftok_pkg::COL_ACC_W-1:0] acc,
        input logic [ftok_pkg::CHAR_W-1:0]    c
    );
        logic [COL_PROD_W-1:0] prod;
        prod = COL_PROD_W'(acc) * COL_PROD_W'(26)
             + COL_PROD_W'(c - ftok_pkg::CH_LETTER_BIAS);
        if (acc > ftok_pkg::COL_ACC_W'(ftok_pkg::MAX_COLS))
            return {1'b0, acc};
        else if (prod > COL_PROD_W'(ftok_pkg::MAX_COLS))
            return {1'b1, ftok_pkg::COL_ACC_W'(ftok_pkg::MAX_COLS + 1)};
        else
            return {1'b0, prod[ftok_pkg::COL_ACC_W-1:0]};
    endfunction

    // Returns {limit hit, new row accumulator}; saturates at MAX_ROWS + 1.
    function automatic logic [ftok_pkg::ROW_ACC_W:0] add_digit(
        input logic [ftok_pkg::ROW_ACC_W-1:0] acc,
        input logic [ftok_pkg::CHAR_W-1:0]    c
    );
        logic [ROW_PROD_W-1:0] prod;
        prod = ROW_PROD_W'(acc) * ROW_PROD_W'(10) + ROW_PROD_W'(c - ftok_pkg::CH_ZERO);
        if (acc > ftok_pkg::ROW_ACC_W'(ftok_pkg::MAX_ROWS))
            return {1'b0, acc};
        else if (prod > ROW_PROD_W'(ftok_pkg::MAX_ROWS))
            return {1'b1, ftok_pkg::ROW_ACC_W'(ftok_pkg::MAX_ROWS + 1)};
        else
            return {1'b0, prod[ftok_pkg::ROW_ACC_W-1:0]};
    endfunction

    function automatic ftok_pkg::token_t make_tok(
        input logic [ftok_pkg::TYPE_W-1:0]  t,
        input logic [ftok_pkg::START_W-1:0] s,
        input logic [ftok_pkg::LEN_W-1:0]   l,
        input logic [ftok_pkg::ERR_W-1:0]   e
    );
        ftok_pkg::token_t r;
        r              = '0;
        r.token_type   = t;
        r.token_start  = s;
        r.token_length = l;
        r.error_code   = e;
        return r;
    endfunction

    assign pend_len   = ftok_pkg::LEN_W'(pos_reg - ftok_pkg::POS_W'(pstart_reg));
    assign pend_start = ftok_pkg::START_W'(pstart_reg);

    assign letter_cont  = add_letter(col_reg, ch);
    assign letter_first = add_letter('0, ch);
    assign digit_cont   = add_digit(row_reg, ch);
    assign digit_first  = add_digit('0, ch);

    // Closing a cell reference: limit beats row zero.
    always_comb
    begin
        cell_ok = 1'b0;
        if (lim_reg)
            cell_tok = make_tok(ftok_pkg::TK_ERROR, pend_start, pend_len, ftok_pkg::ERR_LIMIT);
        else if (row_reg == '0)
            cell_tok = make_tok(ftok_pkg::TK_ERROR, pend_start, pend_len,
                                ftok_pkg::ERR_ROW_ZERO);
        else
        begin
            cell_ok           = 1'b1;
            cell_tok          = make_tok(ftok_pkg::TK_CELL, pend_start, pend_len,
                                         ftok_pkg::ERR_NONE);
            cell_tok.cell_col = ftok_pkg::COL_W'(col_reg - ftok_pkg::COL_ACC_W'(1));
            cell_tok.cell_row = ftok_pkg::ROW_W'(row_reg - ftok_pkg::ROW_ACC_W'(1));
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        lim_next    = lim_reg;
        consumed    = 1'b0;
        push_a      = 1'b0;
        push_b      = 1'b0;
        tok_a       = '0;
        tok_b       = '0;

        if (kind)
        begin
            unique case (mode_reg)
                ftok_pkg::MODE_NUMBER:
                begin
                    push_a = 1'b1;
                    tok_a  = make_tok(ftok_pkg::TK_NUMBER, pend_start, pend_len,
                                      ftok_pkg::ERR_NONE);
                end
                ftok_pkg::MODE_LETTERS:
                begin
                    push_a = 1'b1;
                    tok_a  = make_tok(ftok_pkg::TK_ERROR, pend_start, pend_len,
                                      ftok_pkg::ERR_NO_ROW);
                end
                ftok_pkg::MODE_DIGITS:
                begin
                    push_a = 1'b1;
                    tok_a  = cell_tok;
                end
                default:
                begin
                end
            endcase
            push_b      = 1'b1;
            tok_b       = make_tok(ftok_pkg::TK_END, ftok_pkg::START_W'(pos_reg), '0,
                                   ftok_pkg::ERR_NONE);
            mode_next   = ftok_pkg::MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
            col_next    = '0;
            row_next    = '0;
            lim_next    = 1'b0;
        end
        else if (mode_reg == ftok_pkg::MODE_ERROR)
        begin
        end
        else if (pos_reg >= ftok_pkg::POS_W'(ftok_pkg::MAX_LEN))
        begin
            push_a    = 1'b1;
            tok_a     = make_tok(ftok_pkg::TK_ERROR, '0, ftok_pkg::LEN_W'(pos_reg),
                                 ftok_pkg::ERR_LIMIT);
            mode_next = ftok_pkg::MODE_ERROR;
        end
        else
        begin
            pos_next = pos_reg + ftok_pkg::POS_W'(1);

            unique case (mode_reg)
                ftok_pkg::MODE_NUMBER:
                begin
                    if (is_digit(ch) || (ch == ftok_pkg::CH_DOT))
                        consumed = 1'b1;
                    else
                    begin
                        push_a    = 1'b1;
                        tok_a     = make_tok(ftok_pkg::TK_NUMBER, pend_start, pend_len,
                                             ftok_pkg::ERR_NONE);
                        mode_next = ftok_pkg::MODE_IDLE;
                    end
                end
                ftok_pkg::MODE_LETTERS:
                begin
                    consumed = 1'b1;
                    if (is_upper(ch))
                    begin
                        col_next = letter_cont[ftok_pkg::COL_ACC_W-1:0];
                        lim_next = lim_reg | letter_cont[ftok_pkg::COL_ACC_W];
                    end
                    else if (is_digit(ch))
                    begin
                        row_next  = digit_first[ftok_pkg::ROW_ACC_W-1:0];
                        lim_next  = lim_reg | digit_first[ftok_pkg::ROW_ACC_W];
                        mode_next = ftok_pkg::MODE_DIGITS;
                    end
                    else
                    begin
                        push_a    = 1'b1;
                        tok_a     = make_tok(ftok_pkg::TK_ERROR, pend_start, pend_len,
                                             ftok_pkg::ERR_NO_ROW);
                        mode_next = ftok_pkg::MODE_ERROR;
                    end
                end
                ftok_pkg::MODE_DIGITS:
                begin
                    if (is_digit(ch))
                    begin
                        consumed = 1'b1;
                        row_next = digit_cont[ftok_pkg::ROW_ACC_W-1:0];
                        lim_next = lim_reg | digit_cont[ftok_pkg::ROW_ACC_W];
                    end
                    else
                    begin
                        push_a = 1'b1;
                        tok_a  = cell_tok;
                        if (cell_ok)
                            mode_next = ftok_pkg::MODE_IDLE;
                        else
                        begin
                            consumed  = 1'b1;
                            mode_next = ftok_pkg::MODE_ERROR;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // The character was not absorbed by a running token: it may start one.
            if (!consumed)
            begin
                if (is_space(ch))
                begin
                end
                else if (is_digit(ch))
                begin
                    pstart_next = ftok_pkg::PSTART_W'(pos_reg);
                    mode_next   = ftok_pkg::MODE_NUMBER;
                end
                else if (is_upper(ch))
                begin
                    pstart_next = ftok_pkg::PSTART_W'(pos_reg);
                    col_next    = letter_first[ftok_pkg::COL_ACC_W-1:0];
                    row_next    = '0;
                    lim_next    = letter_first[ftok_pkg::COL_ACC_W];
                    mode_next   = ftok_pkg::MODE_LETTERS;
                end
                else
                begin
                    push_b = 1'b1;
                    unique case (ch)
                        ftok_pkg::CH_PLUS:
                            tok_b = make_tok(ftok_pkg::TK_PLUS, ftok_pkg::START_W'(pos_reg),
                                             ftok_pkg::LEN_W'(1), ftok_pkg::ERR_NONE);
                        ftok_pkg::CH_MINUS:
                            tok_b = make_tok(ftok_pkg::TK_MINUS, ftok_pkg::START_W'(pos_reg),
                                             ftok_pkg::LEN_W'(1), ftok_pkg::ERR_NONE);
                        ftok_pkg::CH_STAR:
                            tok_b = make_tok(ftok_pkg::TK_MUL, ftok_pkg::START_W'(pos_reg),
                                             ftok_pkg::LEN_W'(1), ftok_pkg::ERR_NONE);
                        ftok_pkg::CH_SLASH:
                            tok_b = make_tok(ftok_pkg::TK_DIV, ftok_pkg::START_W'(pos_reg),
                                             ftok_pkg::LEN_W'(1), ftok_pkg::ERR_NONE);
                        ftok_pkg::CH_LPAREN:
                            tok_b = make_tok(ftok_pkg::TK_LPAREN, ftok_pkg::START_W'(pos_reg),
                                             ftok_pkg::LEN_W'(1), ftok_pkg::ERR_NONE);
                        ftok_pkg::CH_RPAREN:
                            tok_b = make_tok(ftok_pkg::TK_RPAREN, ftok_pkg::START_W'(pos_reg),
                                             ftok_pkg::LEN_W'(1), ftok_pkg::ERR_NONE);
                        default:
                        begin
                            tok_b     = make_tok(ftok_pkg::TK_ERROR,
                                                 ftok_pkg::START_W'(pos_reg),
                                                 ftok_pkg::LEN_W'(1), ftok_pkg::ERR_BAD_CHAR);
                            mode_next = ftok_pkg::MODE_ERROR;
                        end
                    endcase
                end
            end
        end

        // The final token caused by this character carries the last flag.
        if (push_b)
            tok_b.last = 1'b1;
        else if (push_a)
            tok_a.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ftok_pkg::MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            lim_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            lim_reg    <= lim_next;
        end
    end

    assign push.push_a = accept && push_a;
    assign push.tok_a  = tok_a;
    assign push.push_b = accept && push_b;
    assign push.tok_b  = tok_b;
    assign mode        = mode_reg;

endmodule

// ===== sv/ftok_out_queue.sv =====
// Small token queue: takes up to two tokens per cycle, hands out one per cycle when popped.
module ftok_out_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ftok_pkg::token_push_t   push,
    input  logic                    pop,
    output logic                    head_valid,
    output ftok_pkg::token_t        head,
    output ftok_pkg::queue_status_t status
);

    ftok_pkg::token_t                q_reg [ftok_pkg::QUEUE_DEPTH];
    logic [ftok_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ftok_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ftok_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic [ftok_pkg::QPTR_W-1:0]     wr_b_ptr;
    logic [1:0]                      n_push;

    assign n_push      = {1'b0, push.push_a} + {1'b0, push.push_b};
    assign wr_b_ptr    = wr_ptr_reg + ftok_pkg::QPTR_W'(push.push_a);
    assign wr_ptr_next = wr_ptr_reg + ftok_pkg::QPTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + ftok_pkg::QPTR_W'(pop);
    assign count_next  = count_reg + ftok_pkg::QCNT_W'(n_push) - ftok_pkg::QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_a)
            q_reg[wr_ptr_reg] <= push.tok_a;
        if (push.push_b)
            q_reg[wr_b_ptr] <= push.tok_b;
    end

    assign head_valid   = (count_reg != '0);
    assign head         = q_reg[rd_ptr_reg];
    // A new character may need two entries.
    assign status.room  = (count_reg <= ftok_pkg::QCNT_W'(ftok_pkg::QUEUE_DEPTH - 2));
    assign status.count = count_reg;

endmodule

// ===== sv/formula_tokenizer_with_cell_decode.sv =====
// Top level of the streaming formula tokenizer with A1 cell reference decoding.
//
// The block takes a spreadsheet formula one character per beat on the chars channel,
// with kind high marking the end of the formula, and returns tokens on the tokens
// channel: numbers, cell references (column and row decoded to zero-based values),
// the four operators, parentheses, errors and a closing end token. Each character is
// worked in one combinational step: the lexer decides from its mode register and the
// incoming byte what to emit and what to keep, and the tokens go straight into a
// four-entry queue whose head drives the tokens channel. A new character is taken
// every cycle while the queue has two free entries; a character that yields two tokens
// (one that closes a number or a cell and starts its own token, or the end marker after
// a pending token) puts two tokens on the output, so while the tokens channel is ready
// the sustained rate is one character per cycle for characters that give at most one
// token, and is set by the one-token-per-cycle output port otherwise. The last flag
// marks the final token caused by one character. After an error the rest of the
// formula is dropped silently up to the end marker, which then gives the end token
// alone and returns the lexer to its reset state. No clearing pass is needed after
// reset.
module formula_tokenizer_with_cell_decode
(
    input  logic               clk,
    input  logic               rst_n,
    ftok_char_if.sink          chars,
    ftok_token_if.source       tokens
);

    `include "formula_tokenizer_with_cell_decode_assert.svh"

    ftok_pkg::token_push_t   push;
    ftok_pkg::lex_mode_t     mode;
    ftok_pkg::queue_status_t qstatus;
    ftok_pkg::token_t        head;
    logic                    head_valid;
    logic                    accept;
    logic                    pop;

    // A character is only taken when the queue can hold everything it might produce.
    assign chars.ready = qstatus.room;
    assign accept      = chars.valid && chars.ready;
    assign pop         = tokens.valid && tokens.ready;

    ftok_lexer u_lexer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (chars.kind),
        .ch     (chars.ch),
        .push   (push),
        .mode   (mode)
    );

    ftok_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .status     (qstatus)
    );

    assign tokens.valid        = head_valid;
    assign tokens.token_type   = head.token_type;
    assign tokens.token_start  = head.token_start;
    assign tokens.token_length = head.token_length;
    assign tokens.cell_col     = head.cell_col;
    assign tokens.cell_row     = head.cell_row;
    assign tokens.error_code   = head.error_code;
    assign tokens.last         = head.last;

    // The queue never holds more entries than it has.
    `FTOK_ASSERT_IMP(a_queue_bound, 1'b1, qstatus.count <= ftok_pkg::QCNT_W'(ftok_pkg::QUEUE_DEPTH), "token queue overflow")

    // Once an error has been reported, ordinary characters produce nothing.
    `FTOK_ASSERT_IMP(a_error_silent, accept && !chars.kind && mode == ftok_pkg::MODE_ERROR, !push.push_a && !push.push_b, "token emitted after an error")

    // The end marker always closes the formula and brings the lexer back to idle.
    `FTOK_ASSERT_NEXT(a_end_resets, accept && chars.kind, mode == ftok_pkg::MODE_IDLE, "lexer not idle after end marker")

    // An end token is always the final beat for its character.
    `FTOK_ASSERT_IMP(a_end_is_last, tokens.valid && tokens.token_type == ftok_pkg::TK_END, tokens.last, "end token without last")

endmodule

// ===== tb/sv/tb_formula_tokenizer_with_cell_decode.sv =====
// Self-checking testbench for the streaming formula tokenizer with A1 cell decoding.
`timescale 1ns / 100ps

module tb_formula_tokenizer_with_cell_decode;

    // Cycles with no beat on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last token before the verdict is printed.
    localparam int TAIL_CYCLES    = 16;
    localparam int COL_RADIX      = 26;
    localparam int ROW_RADIX      = 10;

    logic clk;
    logic rst_n;

    ftok_char_if  chars_if();
    ftok_token_if tokens_if();

    formula_tokenizer_with_cell_decode u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    // ------------------------------------------------------------------
    // Lexer prediction. This is an independent copy of the lexer state,
    // advanced once for every character beat that the block accepts.
    // ------------------------------------------------------------------
    ftok_pkg::lex_mode_t scan_mode;
    int        char_count;     // characters lexed so far in this formula, up to an error
    int        token_origin;   // position of the first character of the open token
    int        col_value;      // bijective base 26 column, saturating at limit + 1
    int        row_value;      // decimal row, saturating at limit + 1
    bit        past_limit;     // the open cell has gone past a column or row limit

    ftok_pkg::token_t lexed_tokens[2];
    ftok_pkg::token_t expected_tokens[$];

    int        mismatches = 0;
    int        live_chars = 0; // beats that the lexer did not simply drop
    bit        idle_en;        // random idling on both channels

    function automatic void reset_lexer();
        scan_mode    = ftok_pkg::MODE_IDLE;
        char_count   = 0;
        token_origin = 0;
        col_value    = 0;
        row_value    = 0;
        past_limit   = 1'b0;
    endfunction

    function automatic bit digit_char(input logic [ftok_pkg::CHAR_W-1:0] c);
        return c >= ftok_pkg::CH_ZERO && c <= ftok_pkg::CH_NINE;
    endfunction

    function automatic bit upper_char(input logic [ftok_pkg::CHAR_W-1:0] c);
        return c >= ftok_pkg::CH_UPPER_A && c <= ftok_pkg::CH_UPPER_Z;
    endfunction

    function automatic bit blank_char(input logic [ftok_pkg::CHAR_W-1:0] c);
        return c == ftok_pkg::CH_SPACE || (c >= ftok_pkg::CH_TAB && c <= ftok_pkg::CH_CR);
    endfunction

    // Builds one token, cutting every value down to the width of its field.
    function automatic ftok_pkg::token_t pack_token(
        input logic [ftok_pkg::TYPE_W-1:0] kind_of_token,
        input int start, input int len,
        input int col, input int row,
        input logic [ftok_pkg::ERR_W-1:0] err);
        ftok_pkg::token_t t;
        t.token_type   = kind_of_token;
        t.token_start  = start[ftok_pkg::START_W-1:0];
        t.token_length = len[ftok_pkg::LEN_W-1:0];
        t.cell_col     = col[ftok_pkg::COL_W-1:0];
        t.cell_row     = row[ftok_pkg::ROW_W-1:0];
        t.error_code   = err;
        t.last         = 1'b0;
        return t;
    endfunction

    function automatic void push_column_letter(input logic [ftok_pkg::CHAR_W-1:0] c);
        int v;
        if (col_value > ftok_pkg::MAX_COLS)
            return;
        v = col_value * COL_RADIX + (int'(c) - int'(ftok_pkg::CH_LETTER_BIAS));
        if (v > ftok_pkg::MAX_COLS)
        begin
            past_limit = 1'b1;
            v = ftok_pkg::MAX_COLS + 1;
        end
        col_value = v;
    endfunction

    function automatic void push_row_digit(input logic [ftok_pkg::CHAR_W-1:0] c);
        int v;
        if (row_value > ftok_pkg::MAX_ROWS)
            return;
        v = row_value * ROW_RADIX + (int'(c) - int'(ftok_pkg::CH_ZERO));
        if (v > ftok_pkg::MAX_ROWS)
        begin
            past_limit = 1'b1;
            v = ftok_pkg::MAX_ROWS + 1;
        end
        row_value = v;
    endfunction

    // Closes an open cell reference. A limit overrun outranks a zero row.
    function automatic ftok_pkg::token_t close_cell(input int end_pos);
        int len;
        len = end_pos - token_origin;
        if (past_limit)
            return pack_token(ftok_pkg::TK_ERROR, token_origin, len, 0, 0,
                              ftok_pkg::ERR_LIMIT);
        if (row_value == 0)
            return pack_token(ftok_pkg::TK_ERROR, token_origin, len, 0, 0,
                              ftok_pkg::ERR_ROW_ZERO);
        return pack_token(ftok_pkg::TK_CELL, token_origin, len, col_value - 1,
                          row_value - 1, ftok_pkg::ERR_NONE);
    endfunction

    // Advances the lexer by one beat and leaves the tokens it causes in
    // lexed_tokens; returns how many there are.
    function automatic int lex_char(input logic is_end,
                                    input logic [ftok_pkg::CHAR_W-1:0] c);
        int                          n;
        int                          here;
        bit                          taken;
        logic [ftok_pkg::TYPE_W-1:0] op;
        n     = 0;
        taken = 1'b0;
        lexed_tokens[0] = '0;
        lexed_tokens[1] = '0;
        if (is_end)
        begin
            // The end marker flushes whatever token is still open.
            case (scan_mode)
                ftok_pkg::MODE_NUMBER:
                begin
                    lexed_tokens[n] = pack_token(ftok_pkg::TK_NUMBER, token_origin,
                                                 char_count - token_origin, 0, 0,
                                                 ftok_pkg::ERR_NONE);
                    n++;
                end
                ftok_pkg::MODE_LETTERS:
                begin
                    lexed_tokens[n] = pack_token(ftok_pkg::TK_ERROR, token_origin,
                                                 char_count - token_origin, 0, 0,
                                                 ftok_pkg::ERR_NO_ROW);
                    n++;
                end
                ftok_pkg::MODE_DIGITS:
                begin
                    lexed_tokens[n] = close_cell(char_count);
                    n++;
                end
                default:
                begin
                end
            endcase
            lexed_tokens[n] = pack_token(ftok_pkg::TK_END, char_count, 0, 0, 0,
                                         ftok_pkg::ERR_NONE);
            n++;
            reset_lexer();
        end
        else if (scan_mode == ftok_pkg::MODE_ERROR)
        begin
            // Everything after an error is dropped up to the end marker.
        end
        else if (char_count >= ftok_pkg::MAX_LEN)
        begin
            // The formula has run past its length limit: any open token is lost.
            lexed_tokens[0] = pack_token(ftok_pkg::TK_ERROR, 0, char_count, 0, 0,
                                         ftok_pkg::ERR_LIMIT);
            n = 1;
            scan_mode = ftok_pkg::MODE_ERROR;
        end
        else
        begin
            here = char_count;
            char_count = here + 1;
            case (scan_mode)
                ftok_pkg::MODE_NUMBER:
                begin
                    if (digit_char(c) || c == ftok_pkg::CH_DOT)
                        taken = 1'b1;
                    else
                    begin
                        lexed_tokens[n] = pack_token(ftok_pkg::TK_NUMBER, token_origin,
                                                     here - token_origin, 0, 0,
                                                     ftok_pkg::ERR_NONE);
                        n++;
                        scan_mode = ftok_pkg::MODE_IDLE;
                    end
                end
                ftok_pkg::MODE_LETTERS:
                begin
                    taken = 1'b1;
                    if (upper_char(c))
                        push_column_letter(c);
                    else if (digit_char(c))
                    begin
                        row_value = 0;
                        push_row_digit(c);
                        scan_mode = ftok_pkg::MODE_DIGITS;
                    end
                    else
                    begin
                        // Letters with no row: the character that ends them is lost too.
                        lexed_tokens[n] = pack_token(ftok_pkg::TK_ERROR, token_origin,
                                                     here - token_origin, 0, 0,
                                                     ftok_pkg::ERR_NO_ROW);
                        n++;
                        scan_mode = ftok_pkg::MODE_ERROR;
                    end
                end
                ftok_pkg::MODE_DIGITS:
                begin
                    if (digit_char(c))
                    begin
                        push_row_digit(c);
                        taken = 1'b1;
                    end
                    else
                    begin
                        lexed_tokens[n] = close_cell(here);
                        n++;
                        if (lexed_tokens[n-1].token_type == ftok_pkg::TK_CELL)
                            scan_mode = ftok_pkg::MODE_IDLE;
                        else
                        begin
                            scan_mode = ftok_pkg::MODE_ERROR;
                            taken = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // A character not absorbed by an open token starts its own.
            if (!taken)
            begin
                if (blank_char(c))
                begin
                end
                else if (digit_char(c))
                begin
                    token_origin = here;
                    scan_mode = ftok_pkg::MODE_NUMBER;
                end
                else if (upper_char(c))
                begin
                    token_origin = here;
                    col_value  = 0;
                    row_value  = 0;
                    past_limit = 1'b0;
                    push_column_letter(c);
                    scan_mode = ftok_pkg::MODE_LETTERS;
                end
                else
                begin
                    case (c)
                        ftok_pkg::CH_PLUS:   op = ftok_pkg::TK_PLUS;
                        ftok_pkg::CH_MINUS:  op = ftok_pkg::TK_MINUS;
                        ftok_pkg::CH_STAR:   op = ftok_pkg::TK_MUL;
                        ftok_pkg::CH_SLASH:  op = ftok_pkg::TK_DIV;
                        ftok_pkg::CH_LPAREN: op = ftok_pkg::TK_LPAREN;
                        ftok_pkg::CH_RPAREN: op = ftok_pkg::TK_RPAREN;
                        default:             op = ftok_pkg::TK_ERROR;
                    endcase
                    if (op == ftok_pkg::TK_ERROR)
                    begin
                        lexed_tokens[n] = pack_token(ftok_pkg::TK_ERROR, here, 1, 0, 0,
                                                     ftok_pkg::ERR_BAD_CHAR);
                        scan_mode = ftok_pkg::MODE_ERROR;
                    end
                    else
                        lexed_tokens[n] = pack_token(op, here, 1, 0, 0, ftok_pkg::ERR_NONE);
                    n++;
                end
            end
        end
        if (n > 0)
            lexed_tokens[n-1].last = 1'b1;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the token-side ready.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Ready drops in random bursts while idling is on.
    initial
    begin : token_ready_driver
        int hold;
        hold = 0;
        tokens_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                tokens_if.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                hold = int'($urandom_range(1, 6)) - 1;
                tokens_if.ready <= 1'b0;
            end
            else
                tokens_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Token checking: every token beat is matched against the oldest
    // expected token, field by field.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : token_checker
        ftok_pkg::token_t want;
        if (rst_n === 1'b1 && tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("token beat with nothing expected: type %0d start %0d",
                       tokens_if.token_type, tokens_if.token_start);
                mismatches++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_type",   32'(want.token_type),
                            32'(tokens_if.token_type));
                check_field("token_start",  32'(want.token_start),
                            32'(tokens_if.token_start));
                check_field("token_length", 32'(want.token_length),
                            32'(tokens_if.token_length));
                check_field("cell_col",     32'(want.cell_col),
                            32'(tokens_if.cell_col));
                check_field("cell_row",     32'(want.cell_row),
                            32'(tokens_if.cell_row));
                check_field("error_code",   32'(want.error_code),
                            32'(tokens_if.error_code));
                check_field("last",         32'(want.last),
                            32'(tokens_if.last));
            end
        end
    end

    // The watchdog ends the run if neither channel moves a beat for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("formula_tokenizer_with_cell_decode regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Character stimulus.
    // ------------------------------------------------------------------

    // Sends one character beat, with an optional random gap in front of it,
    // and records the tokens it should cause once the beat is taken.
    task automatic send_char(input logic is_end, input logic [ftok_pkg::CHAR_W-1:0] c);
        int n;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.kind  <= is_end;
        chars_if.ch    <= c;
        @(posedge clk);
        while (chars_if.ready !== 1'b1)
            @(posedge clk);
        if (is_end || scan_mode != ftok_pkg::MODE_ERROR)
            live_chars++;
        n = lex_char(is_end, c);
        for (int i = 0; i < n; i++)
            expected_tokens.push_back(lexed_tokens[i]);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(1'b0, s[i]);
    endtask

    // The byte carried with the end marker is meaningless, so it is random.
    task automatic send_end();
        send_char(1'b1, ftok_pkg::CHAR_W'($urandom_range(0, 255)));
    endtask

    // Holds the character channel idle until every expected token has come.
    task automatic wait_for_tokens();
        chars_if.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ftok_pkg::CHAR_W-1:0] pick_blank();
        if ($urandom_range(0, 1) == 1)
            return ftok_pkg::CH_SPACE;
        return ftok_pkg::CH_TAB + ftok_pkg::CHAR_W'($urandom_range(0, 4));
    endfunction

    function automatic logic [ftok_pkg::CHAR_W-1:0] pick_operator();
        case ($urandom_range(0, 5))
            0:       return ftok_pkg::CH_PLUS;
            1:       return ftok_pkg::CH_MINUS;
            2:       return ftok_pkg::CH_STAR;
            3:       return ftok_pkg::CH_SLASH;
            4:       return ftok_pkg::CH_LPAREN;
            default: return ftok_pkg::CH_RPAREN;
        endcase
    endfunction

    function automatic logic [ftok_pkg::CHAR_W-1:0] pick_letter();
        return ftok_pkg::CH_UPPER_A + ftok_pkg::CHAR_W'($urandom_range(0, 25));
    endfunction

    function automatic logic [ftok_pkg::CHAR_W-1:0] pick_digit();
        return ftok_pkg::CH_ZERO + ftok_pkg::CHAR_W'($urandom_range(0, 9));
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // An end marker on its own gives just the end token at position zero.
    task automatic test_empty_formula();
        send_end();
    endtask

    // Every operator, both parentheses, numbers with a dot, whitespace and
    // the largest cell reference that is still within the limits. Several
    // characters here close a token and open their own, giving two tokens.
    task automatic test_token_kinds();
        send_text("(A1 +XFD1048576)*9.5/\tB2-7");
        send_end();
    endtask

    // A dot cannot start a token, nor can a byte with its top bit set; the
    // rest of the formula is dropped after either.
    task automatic test_bad_characters();
        send_text(".1");
        send_end();
        send_text("1");
        send_char(1'b0, 8'hFF);
        send_text("+");
        send_end();
    endtask

    // Letters with no row (ended by an operator and by the end marker), a
    // zero row with leading zeros, and column and row overruns; the column
    // overrun comes with a zero row to show that the limit error wins.
    task automatic test_cell_reference_errors();
        send_text("AB+C1");
        send_end();
        send_text("Q");
        send_end();
        send_text("A00");
        send_end();
        send_text("XFE0");
        send_end();
        send_text("A1048577 ");
        send_end();
    endtask

    // The formula overruns the length limit while a cell is open: the cell
    // is lost, the limit error spans the formula, and the end token's start
    // wraps to zero.
    task automatic test_formula_too_long();
        repeat (ftok_pkg::MAX_LEN - 1) send_char(1'b0, pick_blank());
        send_text("B3+");
        send_end();
    endtask

    // Random formulas, mostly well formed: cell references, numbers,
    // operators and whitespace in random order, with the odd bad byte,
    // letters with no row, or plain noise mixed in.
    task automatic test_random_formulas(input int target);
        int first;
        int pick;
        int k;
        first = live_chars;
        while (live_chars - first < target)
        begin
            repeat ($urandom_range(1, 8))
            begin
                pick = int'($urandom_range(0, 99));
                if (pick < 30)
                begin
                    // Three letters reach past the column limit now and then,
                    // four or five always do; seven digits mostly pass the row limit.
                    k = ($urandom_range(0, 15) == 0) ? int'($urandom_range(4, 5))
                                                     : int'($urandom_range(1, 3));
                    repeat (k) send_char(1'b0, pick_letter());
                    repeat ($urandom_range(1, 7))
                        send_char(1'b0, pick_digit());
                end
                else if (pick < 50)
                begin
                    send_char(1'b0, pick_digit());
                    repeat ($urandom_range(0, 4))
                    begin
                        k = int'($urandom_range(0, 10));
                        send_char(1'b0, (k == 10) ? ftok_pkg::CH_DOT
                                                  : ftok_pkg::CH_ZERO + ftok_pkg::CHAR_W'(k));
                    end
                end
                else if (pick < 80)
                    send_char(1'b0, pick_operator());
                else if (pick < 88)
                    repeat ($urandom_range(1, 3)) send_char(1'b0, pick_blank());
                else if (pick < 92)
                begin
                    // Lower case, a lone dot, or a byte from the upper half.
                    case ($urandom_range(0, 2))
                        0:
                            send_char(1'b0, 8'h61 + ftok_pkg::CHAR_W'($urandom_range(0, 25)));
                        1:
                            send_char(1'b0, ftok_pkg::CH_DOT);
                        default:
                            send_char(1'b0, ftok_pkg::CHAR_W'($urandom_range(128, 255)));
                    endcase
                end
                else if (pick < 96)
                begin
                    repeat ($urandom_range(1, 2))
                        send_char(1'b0, pick_letter());
                    send_char(1'b0, ($urandom_range(0, 1) == 1) ? pick_operator()
                                                                : pick_blank());
                end
                else
                    send_char(1'b0, ftok_pkg::CHAR_W'($urandom_range(0, 255)));

                // Tokens are often butted together so that one character both
                // closes a token and opens the next.
                if ($urandom_range(0, 2) == 0)
                    send_char(1'b0, pick_blank());
            end
            send_end();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.kind  <= 1'b0;
        chars_if.ch    <= '0;
        idle_en = 1'b1;
        reset_lexer();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_formula();
        test_token_kinds();
        // The sender stops here until the block has handed back every token.
        wait_for_tokens();
        test_bad_characters();
        test_cell_reference_errors();
        test_formula_too_long();
        test_random_formulas(600);
        wait_for_tokens();
        // The closing stretch runs both channels flat out.
        idle_en = 1'b0;
        test_random_formulas(300);

        wait_for_tokens();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("formula_tokenizer_with_cell_decode regression: pass");
        else
            $display("formula_tokenizer_with_cell_decode regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ftok_pkg.sv
sv/ftok_if.sv
sv/ftok_lexer.sv
sv/ftok_out_queue.sv
sv/formula_tokenizer_with_cell_decode.sv
tb/sv/tb_formula_tokenizer_with_cell_decode.sv
